// ----- rtl/core/dia_pkg.sv -----
// Package for the descriptor index allocator: parameter defaults, field widths,
// operation and register codes, controller states and the controller/datapath bundles.
// No dependencies.
package dia_pkg;

  localparam int DEF_MAX_SLOTS   = 256;
  localparam int DEF_FRAME_SLOTS = 3;
  localparam int DEF_MAX_BLOCK   = 64;

  localparam int FUNC_W   = 2;
  localparam int BSIZE_W  = 7;
  localparam int FIDX_W   = 8;
  localparam int FRAME_W  = 2;
  localparam int SLOT_W   = 8;
  localparam int ADDR_W   = 64;
  localparam int CNT_W    = 9;
  localparam int STRIDE_W = 13;
  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;

  localparam logic [CNT_W-1:0]    RST_COUNT  = 9'd256;
  localparam logic [CNT_W-1:0]    RST_SPLIT  = 9'd64;
  localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd32;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_BLOCK   = 2'd1,
    FN_FREE    = 2'd2,
    FN_RELEASE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_COUNT  = 3'd0,
    REG_SPLIT  = 3'd1,
    REG_STRIDE = 3'd2,
    REG_CPU    = 3'd3,
    REG_GPU    = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_MUL,
    ST_EMIT,
    ST_FAIL,
    ST_PRD,
    ST_PWR,
    ST_PREL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic scan;
    logic mul;
    logic emit;
    logic fail_ld;
    logic zero_ld;
    logic prd;
    logic pwr;
    logic prel;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  blk_ok;
    logic  frame_ok;
    logic  free_ok;
    logic  found;
    logic  scan_end;
    logic  emit_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- rtl/core/descriptor_index_allocator.sv -----
// Top level of the descriptor index allocator: configuration registers, controller and datapath.
// Depends on dia_pkg, dia_ctrl and dia_datapath.
//
//   Channel   Direction  Handshake                          Payload
//   in_       input      in_valid / in_stall                func, section, block_size, ...
//   out_      output     out_valid / out_stall              slot_index, addresses, fail, last
//   cfg       APB        psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// An item is taken only in the idle state, one at a time; the scan tests one index per cycle.
// Allocations pass dispatch, scan, then multiply and emit for each result; a fruitless scan
// or a bad block size fails. Free and release read, then update, pending state when in range.
// A stalled output holds its result; the next item is still taken meanwhile.
// Reset restores the configuration defaults and frees the slots below the default count.
module descriptor_index_allocator #(
  parameter int MAX_SLOTS   = dia_pkg::DEF_MAX_SLOTS,
  parameter int FRAME_SLOTS = dia_pkg::DEF_FRAME_SLOTS,
  parameter int MAX_BLOCK   = dia_pkg::DEF_MAX_BLOCK
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dia_pkg::FUNC_W-1:0]      in_func,
  input  logic                            in_section,
  input  logic [dia_pkg::BSIZE_W-1:0]     in_block_size,
  input  logic [dia_pkg::FIDX_W-1:0]      in_free_index,
  input  logic [dia_pkg::FRAME_W-1:0]     in_frame_slot,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dia_pkg::SLOT_W-1:0]      out_slot_index,
  output logic [dia_pkg::ADDR_W-1:0]      out_cpu_address,
  output logic [dia_pkg::ADDR_W-1:0]      out_gpu_address,
  output logic                            out_fail,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dia_pkg::PADDR_W-1:0]     paddr,
  input  logic [dia_pkg::PDATA_W-1:0]     pwdata,
  output logic [dia_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [dia_pkg::CNT_W-1:0]    count_r, split_r;
  logic [dia_pkg::STRIDE_W-1:0] stride_r;
  logic [dia_pkg::ADDR_W-1:0]   cpu_r, gpu_r;
  logic                         map_init_r;
  logic                         cfg_wr, in_accept, idle;
  dia_pkg::reg_idx_t            ridx;
  dia_pkg::cmd_t                cmd;
  dia_pkg::sts_t                sts;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign ridx      = dia_pkg::reg_idx_t'(paddr[5:3]);
  assign in_stall  = !idle || map_init_r;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= dia_pkg::RST_COUNT;
      split_r    <= dia_pkg::RST_SPLIT;
      stride_r   <= dia_pkg::RST_STRIDE;
      cpu_r      <= '0;
      gpu_r      <= '0;
      map_init_r <= 1'b0;
    end else begin
      map_init_r <= cfg_wr && (ridx == dia_pkg::REG_COUNT || ridx == dia_pkg::REG_SPLIT);
      if (cfg_wr) begin
        unique case (ridx)
          dia_pkg::REG_COUNT:  count_r  <= pwdata[dia_pkg::CNT_W-1:0];
          dia_pkg::REG_SPLIT:  split_r  <= pwdata[dia_pkg::CNT_W-1:0];
          dia_pkg::REG_STRIDE: stride_r <= pwdata[dia_pkg::STRIDE_W-1:0];
          dia_pkg::REG_CPU:    cpu_r    <= pwdata;
          dia_pkg::REG_GPU:    gpu_r    <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (ridx)
      dia_pkg::REG_COUNT:  prdata = dia_pkg::PDATA_W'(count_r);
      dia_pkg::REG_SPLIT:  prdata = dia_pkg::PDATA_W'(split_r);
      dia_pkg::REG_STRIDE: prdata = dia_pkg::PDATA_W'(stride_r);
      dia_pkg::REG_CPU:    prdata = cpu_r;
      dia_pkg::REG_GPU:    prdata = gpu_r;
      default:             prdata = '0;
    endcase
  end

  dia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  dia_datapath #(
    .MAX_SLOTS   (MAX_SLOTS),
    .FRAME_SLOTS (FRAME_SLOTS),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_func         (in_func),
    .in_section      (in_section),
    .in_block_size   (in_block_size),
    .in_free_index   (in_free_index),
    .in_frame_slot   (in_frame_slot),
    .cfg_count       (count_r),
    .cfg_split       (split_r),
    .cfg_stride      (stride_r),
    .cfg_cpu         (cpu_r),
    .cfg_gpu         (gpu_r),
    .map_init        (map_init_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_slot_index  (out_slot_index),
    .out_cpu_address (out_cpu_address),
    .out_gpu_address (out_gpu_address),
    .out_fail        (out_fail),
    .out_last        (out_last)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("item accepted while another is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fail |-> out_last && out_slot_index == '0 && out_cpu_address == '0
      && out_gpu_address == '0)
    else $error("failed result carries non-zero fields");

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (ridx == dia_pkg::REG_COUNT || ridx == dia_pkg::REG_SPLIT) |=> in_stall)
    else $error("item taken during free map rebuild");

endmodule

// ----- rtl/core/dia_ctrl.sv -----
// Controller state machine of the descriptor index allocator.
// Depends on dia_pkg; drives the command bundle of dia_datapath.
module dia_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  dia_pkg::sts_t sts,
  output dia_pkg::cmd_t cmd,
  output logic          idle
);

  dia_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dia_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    unique case (state_r)
      dia_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_accept) begin
          state_nxt = dia_pkg::ST_DISP;
        end
      end
      dia_pkg::ST_DISP: begin
        unique case (sts.func)
          dia_pkg::FN_ALLOC, dia_pkg::FN_BLOCK: begin
            state_nxt = sts.blk_ok ? dia_pkg::ST_SCAN : dia_pkg::ST_FAIL;
          end
          dia_pkg::FN_FREE: begin
            state_nxt = (sts.frame_ok && sts.free_ok) ? dia_pkg::ST_PRD : dia_pkg::ST_DONE;
          end
          default: begin
            state_nxt = sts.frame_ok ? dia_pkg::ST_PRD : dia_pkg::ST_DONE;
          end
        endcase
      end
      dia_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = dia_pkg::ST_FAIL;
        end else if (sts.found) begin
          state_nxt = dia_pkg::ST_MUL;
        end
      end
      dia_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = dia_pkg::ST_EMIT;
      end
      dia_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.emit_last ? dia_pkg::ST_IDLE : dia_pkg::ST_MUL;
        end
      end
      dia_pkg::ST_FAIL: begin
        if (sts.out_free) begin
          cmd.fail_ld = 1'b1;
          state_nxt   = dia_pkg::ST_IDLE;
        end
      end
      dia_pkg::ST_PRD: begin
        cmd.prd   = 1'b1;
        state_nxt = (sts.func == dia_pkg::FN_FREE) ? dia_pkg::ST_PWR : dia_pkg::ST_PREL;
      end
      dia_pkg::ST_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = dia_pkg::ST_DONE;
      end
      dia_pkg::ST_PREL: begin
        cmd.prel  = 1'b1;
        state_nxt = dia_pkg::ST_DONE;
      end
      dia_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.zero_ld = 1'b1;
          state_nxt   = dia_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dia_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/dia_datapath.sv -----
// Datapath of the descriptor index allocator: free map, pending-free memory,
// scan counters, address arithmetic and the output register. Depends on dia_pkg.
module dia_datapath #(
  parameter int MAX_SLOTS   = dia_pkg::DEF_MAX_SLOTS,
  parameter int FRAME_SLOTS = dia_pkg::DEF_FRAME_SLOTS,
  parameter int MAX_BLOCK   = dia_pkg::DEF_MAX_BLOCK
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_accept,
  input  logic [dia_pkg::FUNC_W-1:0]     in_func,
  input  logic                           in_section,
  input  logic [dia_pkg::BSIZE_W-1:0]    in_block_size,
  input  logic [dia_pkg::FIDX_W-1:0]     in_free_index,
  input  logic [dia_pkg::FRAME_W-1:0]    in_frame_slot,
  input  logic [dia_pkg::CNT_W-1:0]      cfg_count,
  input  logic [dia_pkg::CNT_W-1:0]      cfg_split,
  input  logic [dia_pkg::STRIDE_W-1:0]   cfg_stride,
  input  logic [dia_pkg::ADDR_W-1:0]     cfg_cpu,
  input  logic [dia_pkg::ADDR_W-1:0]     cfg_gpu,
  input  logic                           map_init,
  input  dia_pkg::cmd_t                  cmd,
  output dia_pkg::sts_t                  sts,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [dia_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [dia_pkg::ADDR_W-1:0]     out_cpu_address,
  output logic [dia_pkg::ADDR_W-1:0]     out_gpu_address,
  output logic                           out_fail,
  output logic                           out_last
);

  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int CW  = IW + 1;
  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int FW  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int FXW = (FW > dia_pkg::FRAME_W) ? FW : dia_pkg::FRAME_W;
  localparam int XW  = (CW > dia_pkg::CNT_W) ? CW : dia_pkg::CNT_W;
  localparam int OW  = CW + dia_pkg::STRIDE_W;
  localparam int RST_N = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

  logic [XW-1:0]        cnt_x, n_x, sp_x;
  logic [CW-1:0]        n_c, sp_c;
  logic [MAX_SLOTS-1:0] init_map, rst_map;

  dia_pkg::func_t       func_r;
  logic [BW-1:0]        need_r, run_r, left_r;
  logic                 blk_ok_r, frame_ok_r, free_ok_r;
  logic [FXW-1:0]       frame_r;
  logic [IW-1:0]        fidx_r;
  logic [CW-1:0]        idx_r, hi_r, cur_r;
  logic [OW-1:0]        off_r;
  logic [MAX_SLOTS-1:0] free_map_r;
  logic [MAX_SLOTS-1:0] pend_mem [FRAME_SLOTS];
  logic [MAX_SLOTS-1:0] row_r, row_eff;
  logic                 row_ok_r;
  logic [FRAME_SLOTS-1:0] pvalid_r;
  logic                 bit_cur, hit, scan_end, out_free;
  logic                 out_valid_r;
  logic [dia_pkg::SLOT_W-1:0] slot_r;
  logic [dia_pkg::ADDR_W-1:0] cpu_r, gpu_r;
  logic                 fail_r, last_r;
  logic [BW-1:0]        bs_b;
  logic                 bs_ok;

  always_comb begin
    cnt_x = XW'(cfg_count);
    n_x   = (cnt_x > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS) : cnt_x;
    sp_x  = (XW'(cfg_split) > n_x) ? n_x : XW'(cfg_split);
    n_c   = CW'(n_x);
    sp_c  = CW'(sp_x);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      init_map[i] = (i < 32'(n_c));
      rst_map[i]  = (i < RST_N);
    end
  end

  always_comb begin
    bs_ok = (in_block_size != '0) && (32'(in_block_size) <= MAX_BLOCK);
    bs_b  = BW'(in_block_size);
  end

  assign bit_cur  = free_map_r[idx_r[IW-1:0]];
  assign scan_end = (idx_r >= hi_r);
  assign hit      = bit_cur && (BW'(run_r + BW'(1)) == need_r);
  assign row_eff  = row_ok_r ? row_r : '0;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts.func      = func_r;
    sts.blk_ok    = blk_ok_r;
    sts.frame_ok  = frame_ok_r;
    sts.free_ok   = free_ok_r;
    sts.found     = hit && !scan_end;
    sts.scan_end  = scan_end;
    sts.emit_last = (left_r == BW'(1));
    sts.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r     <= dia_pkg::func_t'(in_func);
      frame_r    <= FXW'(in_frame_slot);
      frame_ok_r <= (32'(in_frame_slot) < FRAME_SLOTS);
      fidx_r     <= IW'(in_free_index);
      free_ok_r  <= (XW'(in_free_index) < n_x);
      idx_r      <= in_section ? sp_c : '0;
      hi_r       <= in_section ? n_c : sp_c;
      run_r      <= '0;
      if (dia_pkg::func_t'(in_func) == dia_pkg::FN_ALLOC) begin
        need_r   <= BW'(1);
        blk_ok_r <= 1'b1;
      end else begin
        need_r   <= bs_b;
        blk_ok_r <= bs_ok;
      end
    end else if (cmd.scan && !scan_end) begin
      if (hit) begin
        cur_r  <= CW'(idx_r + CW'(1) - CW'(need_r));
        left_r <= need_r;
      end else begin
        run_r <= bit_cur ? BW'(run_r + BW'(1)) : '0;
        idx_r <= idx_r + CW'(1);
      end
    end else if (cmd.emit) begin
      cur_r  <= cur_r + CW'(1);
      left_r <= left_r - BW'(1);
    end
    if (cmd.mul) begin
      off_r <= OW'(cur_r) * OW'(cfg_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= rst_map;
      pvalid_r   <= '0;
    end else if (map_init) begin
      free_map_r <= init_map;
      pvalid_r   <= '0;
    end else begin
      if (cmd.mul) begin
        free_map_r[cur_r[IW-1:0]] <= 1'b0;
      end
      if (cmd.prel) begin
        free_map_r <= free_map_r | row_eff;
        pvalid_r[frame_r[FW-1:0]] <= 1'b0;
      end
      if (cmd.pwr) begin
        pvalid_r[frame_r[FW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prd) begin
      row_r    <= pend_mem[frame_r[FW-1:0]];
      row_ok_r <= pvalid_r[frame_r[FW-1:0]];
    end
    if (cmd.pwr) begin
      pend_mem[frame_r[FW-1:0]] <= row_eff | (MAX_SLOTS'(1) << fidx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.fail_ld || cmd.zero_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      slot_r <= dia_pkg::SLOT_W'(cur_r);
      cpu_r  <= cfg_cpu + dia_pkg::ADDR_W'(off_r);
      gpu_r  <= cfg_gpu + dia_pkg::ADDR_W'(off_r);
      fail_r <= 1'b0;
      last_r <= (left_r == BW'(1));
    end else if (cmd.fail_ld || cmd.zero_ld) begin
      slot_r <= '0;
      cpu_r  <= '0;
      gpu_r  <= '0;
      fail_r <= cmd.fail_ld;
      last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_index  = slot_r;
  assign out_cpu_address = cpu_r;
  assign out_gpu_address = gpu_r;
  assign out_fail        = fail_r;
  assign out_last        = last_r;

endmodule
